>>> rtl/ideq_pkg.sv
// Shared types and codes for the indexed double-ended queue.
package ideq_pkg;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_READ       = 3'd4,
      CMD_INSERT     = 3'd5,
      CMD_ERASE      = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Action broadcast to every cell of the row.
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_ERASE  = 2'd2
   } cell_op_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_DONE = 3'b100
   } state_type;

endpackage

>>> rtl/ideq_if.sv
// Valid/ready channel interfaces for requests and responses.
interface ideq_req_if #(
   parameter int CNT_W  = 9,
   parameter int DATA_W = 32
) ();
   logic              valid;
   logic              ready;
   logic [2:0]        cmd;
   logic [CNT_W-1:0]  position;
   logic [DATA_W-1:0] value;

   modport source (output valid, output cmd, output position, output value, input ready);
   modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

interface ideq_rsp_if #(
   parameter int CNT_W  = 9,
   parameter int DATA_W = 32
) ();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [DATA_W-1:0] read_value;
   logic [CNT_W-1:0]  count;

   modport source (output valid, output status, output read_value, output count, input ready);
   modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

>>> rtl/ideq_cell.sv
// One storage cell of the queue row: element register plus read tap stage.
module ideq_cell #(
   parameter int CNT_W  = 9,
   parameter int DATA_W = 32,
   parameter int INDEX  = 0
) (
   input  logic                  clock,
   input  ideq_pkg::cell_op_type op,
   input  logic [CNT_W-1:0]      pos,
   input  logic [CNT_W-1:0]      read_pos,
   input  logic [DATA_W-1:0]     value,
   input  logic [DATA_W-1:0]     left_data,
   input  logic [DATA_W-1:0]     right_data,
   input  logic [DATA_W-1:0]     right_tap,
   output logic [DATA_W-1:0]     data_out,
   output logic [DATA_W-1:0]     tap_out
);

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic [DATA_W-1:0] data_ff, data_in;
   logic [DATA_W-1:0] tap_ff,  tap_in;

   always_comb begin
      data_in = data_ff;
      case (op)
         ideq_pkg::OP_INSERT: begin
            if (IDX == pos) data_in = value;
            else if (IDX > pos) data_in = left_data;
         end
         ideq_pkg::OP_ERASE: begin
            if (IDX >= pos) data_in = right_data;
         end
         default: data_in = data_ff;
      endcase
   end

   // Capture own element when addressed, otherwise pass the right neighbor's tap.
   assign tap_in = (IDX == read_pos) ? data_ff : right_tap;

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      tap_ff  <= tap_in;
   end

   assign data_out = data_ff;
   assign tap_out  = tap_ff;

endmodule

>>> rtl/indexed_double_ended_queue_top.sv
// Indexed double-ended queue built as a row of shifting cells.
//
//   channel   direction  handshake           payload
//   req_ch    in         valid/ready         cmd, position, value
//   rsp_ch    out        valid/ready         status, read_value, count
//
// Elements sit in logical order, front in cell 0. Every cell loads from its
// left or right neighbor in parallel, so push, pop, insert and erase finish as
// the item is taken; the result then waits in ST_DONE for the output register.
// A read walks the tap chain toward cell 0 and waits in ST_READ longer for a
// deeper position; the tap chain spans all CAPACITY cells.
// Reset (synchronous, active high) empties the queue; cell contents are not cleared.
// A new item is taken while the previous result still waits on rsp_ch.
module indexed_double_ended_queue_top #(
   parameter int CAPACITY   = 256,
   parameter int ELEM_WIDTH = 32
) (
   input logic clock,
   input logic reset,
   ideq_req_if.sink   req_ch,
   ideq_rsp_if.source rsp_ch
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

   ideq_pkg::state_type   state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      rd_pos_ff, rd_pos_in;
   logic [CNT_W-1:0]      wait_ff, wait_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [ELEM_WIDTH-1:0] res_data_ff, res_data_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            rsp_status_ff;
   logic [ELEM_WIDTH-1:0] rsp_data_ff;
   logic [CNT_W-1:0]      rsp_count_ff;

   logic                  accept;
   logic                  load_out;
   ideq_pkg::cell_op_type cell_op;
   logic [CNT_W-1:0]      cell_pos;
   ideq_pkg::status_type  status_c;
   logic [CNT_W-1:0]      count_c;
   logic                  go_read;
   logic                  full;
   logic                  empty;

   logic [ELEM_WIDTH-1:0] data_row [CAPACITY];
   logic [ELEM_WIDTH-1:0] tap_row  [CAPACITY];

   assign req_ch.ready = (state_ff == ideq_pkg::ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == CAP_C);
   assign empty        = (count_ff == '0);

   // Decode the command into a row action, a status and the new count.
   always_comb begin
      cell_op  = ideq_pkg::OP_HOLD;
      cell_pos = req_ch.position;
      status_c = ideq_pkg::STAT_OK;
      count_c  = count_ff;
      go_read  = 1'b0;
      unique case (req_ch.cmd)
         ideq_pkg::CMD_PUSH_FRONT: begin
            if (full) status_c = ideq_pkg::STAT_FULL;
            else begin
               cell_op  = ideq_pkg::OP_INSERT;
               cell_pos = '0;
               count_c  = count_ff + ONE_C;
            end
         end
         ideq_pkg::CMD_PUSH_BACK: begin
            if (full) status_c = ideq_pkg::STAT_FULL;
            else begin
               cell_op  = ideq_pkg::OP_INSERT;
               cell_pos = count_ff;
               count_c  = count_ff + ONE_C;
            end
         end
         ideq_pkg::CMD_POP_FRONT: begin
            if (empty) status_c = ideq_pkg::STAT_RANGE;
            else begin
               cell_op  = ideq_pkg::OP_ERASE;
               cell_pos = '0;
               count_c  = count_ff - ONE_C;
            end
         end
         ideq_pkg::CMD_POP_BACK: begin
            if (empty) status_c = ideq_pkg::STAT_RANGE;
            else count_c = count_ff - ONE_C;
         end
         ideq_pkg::CMD_READ: begin
            if (req_ch.position < count_ff) go_read = 1'b1;
            else status_c = ideq_pkg::STAT_RANGE;
         end
         ideq_pkg::CMD_INSERT: begin
            if (req_ch.position > count_ff) status_c = ideq_pkg::STAT_RANGE;
            else if (full) status_c = ideq_pkg::STAT_FULL;
            else begin
               cell_op = ideq_pkg::OP_INSERT;
               count_c = count_ff + ONE_C;
            end
         end
         ideq_pkg::CMD_ERASE: begin
            if (req_ch.position >= count_ff) status_c = ideq_pkg::STAT_RANGE;
            else begin
               cell_op = ideq_pkg::OP_ERASE;
               count_c = count_ff - ONE_C;
            end
         end
         default: status_c = ideq_pkg::STAT_RANGE;
      endcase
      // Leave the row untouched unless an item is taken this cycle.
      if (!accept) cell_op = ideq_pkg::OP_HOLD;
   end

   // The row of cells. Cell 0 is the front; taps flow toward cell 0.
   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [ELEM_WIDTH-1:0] left_d, right_d, right_t;
      if (k == 0) begin : g_first
         assign left_d = req_ch.value;
      end else begin : g_mid_l
         assign left_d = data_row[k-1];
      end
      if (k == CAPACITY - 1) begin : g_last
         assign right_d = '0;
         assign right_t = '0;
      end else begin : g_mid_r
         assign right_d = data_row[k+1];
         assign right_t = tap_row[k+1];
      end
      ideq_cell #(
         .CNT_W  (CNT_W),
         .DATA_W (ELEM_WIDTH),
         .INDEX  (k)
      ) u_cell (
         .clock      (clock),
         .op         (cell_op),
         .pos        (cell_pos),
         .read_pos   (rd_pos_ff),
         .value      (req_ch.value),
         .left_data  (left_d),
         .right_data (right_d),
         .right_tap  (right_t),
         .data_out   (data_row[k]),
         .tap_out    (tap_row[k])
      );
   end

   // Load the output register in ST_DONE when it is empty or being taken this cycle.
   assign load_out = (state_ff == ideq_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_pos_in     = rd_pos_ff;
      wait_in       = wait_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      unique case (state_ff)
         ideq_pkg::ST_IDLE: begin
            if (accept) begin
               count_in      = count_c;
               res_status_in = status_c;
               res_data_in   = '0;
               if (go_read) begin
                  rd_pos_in = req_ch.position;
                  wait_in   = '0;
                  state_in  = ideq_pkg::ST_READ;
               end else begin
                  state_in = ideq_pkg::ST_DONE;
               end
            end
         end
         ideq_pkg::ST_READ: begin
            // Wait for the addressed element to walk the tap chain to cell 0's tap.
            wait_in = wait_ff + ONE_C;
            if (wait_ff == rd_pos_ff + ONE_C) begin
               res_data_in = tap_row[0];
               state_in    = ideq_pkg::ST_DONE;
            end
         end
         ideq_pkg::ST_DONE: begin
            if (load_out) state_in = ideq_pkg::ST_IDLE;
         end
         default: state_in = ideq_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ideq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers; hold unless loaded.
   always_ff @(posedge clock) begin
      rd_pos_ff     <= rd_pos_in;
      wait_ff       <= wait_in;
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      if (load_out) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.read_value = rsp_data_ff;
   assign rsp_ch.count      = rsp_count_ff;

endmodule

>>> rtl/ideq_checker.sv
// Port-level checks for the indexed double-ended queue, bound to the top level.
module ideq_checker #(
   parameter int CNT_W    = 9,
   parameter int DATA_W   = 32,
   parameter int CAPACITY = 256
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [1:0]        rsp_status,
   input logic [DATA_W-1:0] rsp_read_value,
   input logic [CNT_W-1:0]  rsp_count
);

   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

   // One item in flight: an accepted item closes the request side next cycle.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another item is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_value) && $stable(rsp_count)))
      else $error("stalled response changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= CAP_C))
      else $error("count above capacity");

   a_full_means_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ideq_pkg::STAT_FULL)) |-> (rsp_count == CAP_C))
      else $error("full status with room left");

   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ideq_pkg::STAT_OK)) |-> (rsp_read_value == '0))
      else $error("read data on a failed item");

endmodule

bind indexed_double_ended_queue_top ideq_checker #(
   .CNT_W    (CNT_W),
   .DATA_W   (ELEM_WIDTH),
   .CAPACITY (CAPACITY)
) u_ideq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_read_value (rsp_ch.read_value),
   .rsp_count      (rsp_ch.count)
);

>>> dv/ideq_result_checker.sv
// Response checker for the indexed double-ended queue: predicts each result and compares it.
`timescale 1ns / 1ps
module ideq_result_checker #(
   parameter int CAPACITY = 256
) (
   input  logic clock,
   input  logic reset,
   ideq_req_if  req_ch,
   ideq_rsp_if  rsp_ch,
   output int   fail_count,
   output int   pending_count
);

   typedef struct packed {
      ideq_pkg::status_type status;
      logic [31:0]          read_value;
      logic [8:0]           count;
   } rsp_fields_type;

   logic [31:0]    held_elems[$];   // queue contents, front first
   rsp_fields_type due_results[$];
   int             mismatches = 0;

   function automatic rsp_fields_type apply_request(input logic [2:0] cmd, input int pos,
                                                    input logic [31:0] val);
      rsp_fields_type r;
      r.status     = ideq_pkg::STAT_OK;
      r.read_value = '0;
      case (cmd) inside
         ideq_pkg::CMD_PUSH_FRONT, ideq_pkg::CMD_PUSH_BACK: begin
            if (held_elems.size() >= CAPACITY) begin
               r.status = ideq_pkg::STAT_FULL;
            end else if (cmd == ideq_pkg::CMD_PUSH_FRONT) begin
               held_elems.push_front(val);
            end else begin
               held_elems.push_back(val);
            end
         end
         ideq_pkg::CMD_POP_FRONT, ideq_pkg::CMD_POP_BACK: begin
            if (held_elems.size() == 0) begin
               r.status = ideq_pkg::STAT_RANGE;
            end else if (cmd == ideq_pkg::CMD_POP_FRONT) begin
               void'(held_elems.pop_front());
            end else begin
               void'(held_elems.pop_back());
            end
         end
         ideq_pkg::CMD_READ: begin
            if (pos < held_elems.size()) begin
               r.read_value = held_elems[pos];
            end else begin
               r.status = ideq_pkg::STAT_RANGE;
            end
         end
         ideq_pkg::CMD_INSERT: begin
            // range check wins over the full check
            if (pos > held_elems.size()) begin
               r.status = ideq_pkg::STAT_RANGE;
            end else if (held_elems.size() >= CAPACITY) begin
               r.status = ideq_pkg::STAT_FULL;
            end else begin
               held_elems.insert(pos, val);
            end
         end
         ideq_pkg::CMD_ERASE: begin
            if (pos < held_elems.size()) begin
               held_elems.delete(pos);
            end else begin
               r.status = ideq_pkg::STAT_RANGE;
            end
         end
         default: begin
            r.status = ideq_pkg::STAT_RANGE;
         end
      endcase
      r.count = 9'(held_elems.size());
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_fields_type want;
      if (reset) begin
         held_elems.delete();
         due_results.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            due_results.push_back(apply_request(req_ch.cmd, int'(req_ch.position),
                                                req_ch.value));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_results.size() == 0) begin
               $error("unexpected response: status %0d read_value %0h count %0d",
                      rsp_ch.status, rsp_ch.read_value, rsp_ch.count);
               mismatches++;
            end else begin
               want = due_results.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_ch.status));
               compare_field("read_value", want.read_value, rsp_ch.read_value);
               compare_field("count", 32'(want.count), 32'(rsp_ch.count));
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= due_results.size();
   end

endmodule

>>> dv/tb_indexed_double_ended_queue_top.sv
// Regression top for the indexed double-ended queue: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_indexed_double_ended_queue_top;

   localparam int         CAPACITY     = 256;
   localparam int         RANDOM_ITEMS = 1425;
   localparam int         CALM_ITEMS   = 150;
   localparam int         HOLD_CYCLES  = 600;
   // longest read walks the whole tap chain
   localparam int         TAIL_CYCLES  = CAPACITY + 40;
   localparam logic [2:0] CMD_UNUSED   = 3'd7;

   typedef enum {FILLING, AT_FULL, DRAINING, AT_EMPTY} fill_phase_type;

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   pending_count;

   // stimulus-side view of the fill level, used only to aim positions
   int   level;
   bit   calm;
   bit   rsp_hold_req;
   int   gap_odds;

   ideq_req_if #(.CNT_W(9), .DATA_W(32)) req_ch ();
   ideq_rsp_if #(.CNT_W(9), .DATA_W(32)) rsp_ch ();

   indexed_double_ended_queue_top #(
      .CAPACITY   (CAPACITY),
      .ELEM_WIDTH (32)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   ideq_result_checker #(
      .CAPACITY (CAPACITY)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #2 clock = ~clock;

   // Hard stop: several times the slowest legal run.
   initial begin
      #(10_000_000);
      $display("indexed_double_ended_queue_top regression: fail");
      $finish;
   end

   // Offer one item and hold it until the queue takes it, then maybe idle a burst.
   task automatic send_item(input logic [2:0] cmd, input logic [8:0] pos,
                            input logic [31:0] val);
      req_ch.valid    <= 1'b1;
      req_ch.cmd      <= cmd;
      req_ch.position <= pos;
      req_ch.value    <= val;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      // track the level the same way the queue will
      case (cmd) inside
         ideq_pkg::CMD_PUSH_FRONT, ideq_pkg::CMD_PUSH_BACK: if (level < CAPACITY) level++;
         ideq_pkg::CMD_POP_FRONT, ideq_pkg::CMD_POP_BACK:   if (level > 0) level--;
         ideq_pkg::CMD_INSERT: if (pos <= level && level < CAPACITY) level++;
         ideq_pkg::CMD_ERASE:  if (pos < level) level--;
         default: ;
      endcase
      if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Response side: random stall bursts, one long hold-off on request.
   initial begin
      int rsp_odds;
      int cycles;
      rsp_ch.ready <= 1'b0;
      rsp_odds = 4;
      cycles   = 0;
      forever begin
         @(posedge clock);
         cycles++;
         // re-pick stall density now and then; zero gives clean stretches
         if (cycles % 200 == 0) begin
            case ($urandom_range(0, 2))
               0:       rsp_odds = 0;
               1:       rsp_odds = 3;
               default: rsp_odds = 6;
            endcase
         end
         if (rsp_hold_req) begin
            // hold off long enough for the queue to back up into req_ch
            rsp_hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && rsp_odds != 0 && $urandom_range(1, rsp_odds) == 1) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
      end
   end

   // Request side: reset, directed corners, then random fill/drain cycles.
   initial begin
      fill_phase_type phase;
      int             phase_items;
      int             roll;
      int             n;
      logic [2:0]     cmd;
      logic [8:0]     pos;
      logic [31:0]    val;

      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.cmd      <= ideq_pkg::CMD_PUSH_FRONT;
      req_ch.position <= '0;
      req_ch.value    <= '0;
      level        = 0;
      calm         = 1'b0;
      rsp_hold_req = 1'b0;
      gap_odds     = 4;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty queue: every removal and lookup must be flagged
      send_item(ideq_pkg::CMD_POP_FRONT, 9'd0, 32'h0);
      send_item(ideq_pkg::CMD_POP_BACK, 9'd0, 32'h0);
      send_item(ideq_pkg::CMD_READ, 9'd0, 32'h0);
      send_item(ideq_pkg::CMD_ERASE, 9'd0, 32'h0);
      send_item(ideq_pkg::CMD_INSERT, 9'd1, 32'h1111_1111);
      send_item(CMD_UNUSED, 9'd0, 32'hFFFF_FFFF);
      // insert at position equal to count appends, even on empty
      send_item(ideq_pkg::CMD_INSERT, 9'd0, 32'hA5A5_5A5A);
      send_item(ideq_pkg::CMD_PUSH_FRONT, 9'd0, 32'hFFFF_FFFF);
      send_item(ideq_pkg::CMD_PUSH_BACK, 9'd0, 32'h0000_0000);
      send_item(ideq_pkg::CMD_PUSH_BACK, 9'd0, 32'h8000_0001);
      // both sides equal: the back side shifts, as on every insert
      send_item(ideq_pkg::CMD_INSERT, 9'd2, 32'h1234_5678);
      // back side shorter
      send_item(ideq_pkg::CMD_INSERT, 9'd4, 32'h0F0F_F0F0);
      send_item(ideq_pkg::CMD_INSERT, 9'd6, 32'hDEAD_BEEF);
      send_item(ideq_pkg::CMD_READ, 9'd0, 32'h0);
      send_item(ideq_pkg::CMD_READ, 9'd6, 32'h0);
      send_item(ideq_pkg::CMD_READ, 9'd7, 32'h0);
      send_item(ideq_pkg::CMD_READ, 9'd511, 32'h0);
      send_item(ideq_pkg::CMD_ERASE, 9'd1, 32'h0);
      send_item(ideq_pkg::CMD_ERASE, 9'd5, 32'h0);
      send_item(ideq_pkg::CMD_ERASE, 9'd511, 32'h0);
      send_item(ideq_pkg::CMD_INSERT, 9'd511, 32'h7777_7777);
      send_item(ideq_pkg::CMD_POP_FRONT, 9'd0, 32'h0);
      send_item(ideq_pkg::CMD_POP_BACK, 9'd0, 32'h0);
      send_item(ideq_pkg::CMD_READ, 9'd0, 32'h0);

      phase       = FILLING;
      phase_items = 0;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
         if (n == 250) rsp_hold_req = 1'b1;
         if (n == 700) begin
            // pause until every result is back, then resume
            req_ch.valid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         if (n % 100 == 0) begin
            case ($urandom_range(0, 2))
               0:       gap_odds = 0;
               1:       gap_odds = 3;
               default: gap_odds = 8;
            endcase
         end

         // advance through fill, full, drain, empty
         case (phase)
            FILLING:  if (level == CAPACITY) begin
               phase       = AT_FULL;
               phase_items = 0;
            end
            AT_FULL:  if (phase_items >= 12) phase = DRAINING;
            DRAINING: if (level == 0) begin
               phase       = AT_EMPTY;
               phase_items = 0;
            end
            default:  if (phase_items >= 8) phase = FILLING;
         endcase
         phase_items++;

         case ($urandom_range(0, 9))
            0:       val = 32'h0;
            1:       val = 32'hFFFF_FFFF;
            default: val = $urandom;
         endcase
         roll = $urandom_range(0, 99);
         cmd  = ideq_pkg::CMD_READ;
         if (roll >= 90) begin
            // noise: any code, any position, unused code included
            cmd = 3'($urandom_range(0, 7));
         end else begin
            case (phase)
               FILLING: begin
                  if (roll < 40)      cmd = $urandom_range(0, 1) ? ideq_pkg::CMD_PUSH_BACK
                                                                 : ideq_pkg::CMD_PUSH_FRONT;
                  else if (roll < 75) cmd = ideq_pkg::CMD_INSERT;
                  else if (roll < 83) cmd = ideq_pkg::CMD_READ;
                  else if (roll < 86) cmd = $urandom_range(0, 1) ? ideq_pkg::CMD_POP_BACK
                                                                 : ideq_pkg::CMD_POP_FRONT;
                  else                cmd = ideq_pkg::CMD_ERASE;
               end
               DRAINING: begin
                  if (roll < 40)      cmd = $urandom_range(0, 1) ? ideq_pkg::CMD_POP_BACK
                                                                 : ideq_pkg::CMD_POP_FRONT;
                  else if (roll < 75) cmd = ideq_pkg::CMD_ERASE;
                  else if (roll < 83) cmd = ideq_pkg::CMD_READ;
                  else if (roll < 86) cmd = $urandom_range(0, 1) ? ideq_pkg::CMD_PUSH_BACK
                                                                 : ideq_pkg::CMD_PUSH_FRONT;
                  else                cmd = ideq_pkg::CMD_INSERT;
               end
               AT_FULL: begin
                  if (roll < 35)      cmd = $urandom_range(0, 1) ? ideq_pkg::CMD_PUSH_BACK
                                                                 : ideq_pkg::CMD_PUSH_FRONT;
                  else if (roll < 65) cmd = ideq_pkg::CMD_INSERT;
                  else                cmd = ideq_pkg::CMD_READ;
               end
               default: begin
                  if (roll < 40)      cmd = $urandom_range(0, 1) ? ideq_pkg::CMD_POP_BACK
                                                                 : ideq_pkg::CMD_POP_FRONT;
                  else if (roll < 60) cmd = ideq_pkg::CMD_ERASE;
                  else                cmd = ideq_pkg::CMD_READ;
               end
            endcase
         end

         // aim most positions inside the queue, the rest anywhere in the field
         pos = 9'($urandom_range(0, 511));
         if (roll < 90 && $urandom_range(0, 4) != 0) begin
            if (cmd == ideq_pkg::CMD_INSERT) begin
               pos = 9'($urandom_range(0, level));
            end else if (level > 0) begin
               pos = 9'($urandom_range(0, level - 1));
            end
         end
         send_item(cmd, pos, val);
      end

      // drain: wait for every result, then for the longest read to settle
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("indexed_double_ended_queue_top regression: pass");
      end else begin
         $display("indexed_double_ended_queue_top regression: fail");
      end
      $finish;
   end

endmodule
